// File: design/mik_pkg.sv
// ----------------------------------------------------------------------------
// mik_pkg: shared definitions for the mecanum kinematics limiter
// Field widths, register indexes and reset values, and the control bundle
// that the sequencer sends to the four wheel lanes.
// ----------------------------------------------------------------------------
`default_nettype none

package mik_pkg;

  // Field widths
  localparam int unsigned XY_W       = 12;
  localparam int unsigned ROT_W      = 16;
  localparam int unsigned ARM_W      = 16;
  localparam int unsigned GAIN_W     = 24;
  localparam int unsigned LIM_W      = 15;
  localparam int unsigned MOT_W      = 16;
  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned CFG_IDX_W  = 2;

  // Internal widths
  localparam int unsigned XY_FRAC    = 20;                 // cm/s to Q.20
  localparam int unsigned SUMXY_W    = XY_W + 1;           // x +/- y
  localparam int unsigned RT_W       = ROT_W + ARM_W + 1;  // rot * arm, signed
  localparam int unsigned RT_HI_W    = ROT_W + 1;
  localparam int unsigned LIN_W      = 34;                 // wheel speed, Q.20
  localparam int unsigned ABS_W      = LIN_W - 1;
  localparam int unsigned MAG_W      = 21;                 // motor rpm magnitude
  localparam int unsigned GAIN_DROP  = 36 - GAIN_W;        // further bits dropped after serial mult
  localparam int unsigned CNT_W      = 5;
  localparam int unsigned SAT_W      = MOT_W + 1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ARM_SUM     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_GAIN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_LIMIT = 2'd2;

  // Register reset values
  localparam logic [ARM_W-1:0]  ARM_RST   = 16'd10240;
  localparam logic [GAIN_W-1:0] GAIN_RST  = 24'd1048576;
  localparam logic [LIM_W-1:0]  LIMIT_RST = 15'd8000;

  // Result command codes
  localparam logic CMD_STOP = 1'b0;
  localparam logic CMD_SET  = 1'b1;

  // Saturation bounds as magnitudes
  localparam logic [SAT_W-1:0] SAT_POS = 17'd32767;
  localparam logic [SAT_W-1:0] SAT_NEG = 17'd32768;

  // Lane operations
  typedef enum logic [2:0] {
    LANE_IDLE,
    LANE_LOAD,   // take |wheel speed| and sign, load gain shifter
    LANE_GAIN,   // one gain bit per cycle
    LANE_TAKE,   // latch rpm magnitude, load limit shifter
    LANE_LIM,    // one limit bit per cycle
    LANE_DIV     // one quotient bit per cycle
  } lane_op_e;

  typedef struct packed {
    lane_op_e op;
    logic     limited;
  } lane_ctrl_t;

endpackage

`default_nettype wire

// File: design/mik_vel_if.sv
// ----------------------------------------------------------------------------
// mik_vel_if: chassis velocity command channel
// Valid/ready channel carrying one velocity command per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface mik_vel_if;
  logic                              valid;
  logic                              ready;
  logic signed [mik_pkg::XY_W-1:0]   vel_x;
  logic signed [mik_pkg::XY_W-1:0]   vel_y;
  logic signed [mik_pkg::ROT_W-1:0]  vel_rot;

  modport source (output valid, output vel_x, output vel_y, output vel_rot, input ready);
  modport sink   (input valid, input vel_x, input vel_y, input vel_rot, output ready);
endinterface

`default_nettype wire

// File: design/mik_motor_if.sv
// ----------------------------------------------------------------------------
// mik_motor_if: motor command channel
// Valid/ready channel carrying the command code and four motor speeds.
// ----------------------------------------------------------------------------
`default_nettype none

interface mik_motor_if;
  logic                              valid;
  logic                              ready;
  logic                              command;
  logic signed [mik_pkg::MOT_W-1:0]  motor_one;
  logic signed [mik_pkg::MOT_W-1:0]  motor_two;
  logic signed [mik_pkg::MOT_W-1:0]  motor_three;
  logic signed [mik_pkg::MOT_W-1:0]  motor_four;

  modport source (output valid, output command, output motor_one, output motor_two,
                  output motor_three, output motor_four, input ready);
  modport sink   (input valid, input command, input motor_one, input motor_two,
                  input motor_three, input motor_four, output ready);
endinterface

`default_nettype wire

// File: design/mecanum_inverse_kinematics_limiter_top.sv
// Sequence: a nonzero command runs the serial rotation multiply, the wheel speeds,
// the serial gain multiply and the peak search, then the serial limit multiply and
// divide when the speed limit scales the motors; a first stop goes straight out.
// Throughput: one command at a time; the next transfer is taken once the result
// is in the output register, later if it stalls; a repeated stop gives no result.
// Reset: async active low; registers to their defaults, no stop issued.
// ----------------------------------------------------------------------------
// mecanum_inverse_kinematics_limiter_top: mecanum wheel speed generator
// Turns a chassis velocity command into four motor speeds with gain scaling,
// proportional speed limiting and 16-bit saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module mecanum_inverse_kinematics_limiter_top (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                cfg_we_i,
  input  wire  [mik_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire  [mik_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  mik_vel_if.sink                            vel_i,
  mik_motor_if.source                        mot_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RT,      // rotation times arm, one arm bit per cycle
    ST_LIN,     // four wheel surface speeds
    ST_LOAD,
    ST_GAIN,
    ST_TAKE,
    ST_MAX1,
    ST_MAX2,
    ST_CHECK,
    ST_LIM,
    ST_DIV,
    ST_EMIT
  } state_e;

  localparam int unsigned NLANE = 4;

  state_e                         state_q, state_d;
  logic [mik_pkg::CNT_W-1:0]      cnt_q, cnt_d;
  logic                           stop_sent_q, stop_sent_d;
  logic                           zero_q, zero_d;
  logic                           limited_q, limited_d;
  logic [mik_pkg::ARM_W-1:0]      arm_q, arm_d;
  logic [mik_pkg::GAIN_W-1:0]     gain_q, gain_d;
  logic [mik_pkg::LIM_W-1:0]      limit_q, limit_d;
  logic [mik_pkg::SUMXY_W-1:0]    xmy_q, xmy_d;
  logic [mik_pkg::SUMXY_W-1:0]    xpy_q, xpy_d;
  logic [mik_pkg::ROT_W-1:0]      rot_q, rot_d;
  logic [mik_pkg::RT_HI_W-1:0]    rt_hi_q, rt_hi_d;
  logic [mik_pkg::ARM_W-1:0]      rt_lo_q, rt_lo_d;
  logic [mik_pkg::LIN_W-1:0]      lin_q [NLANE];
  logic [mik_pkg::LIN_W-1:0]      lin_d [NLANE];
  logic [mik_pkg::MAG_W-1:0]      max_a_q, max_a_d;
  logic [mik_pkg::MAG_W-1:0]      max_b_q, max_b_d;
  logic [mik_pkg::MAG_W-1:0]      mx_q, mx_d;
  logic                           out_valid_q, out_valid_d;
  logic                           out_cmd_q, out_cmd_d;
  logic [mik_pkg::MOT_W-1:0]      out_mot_q [NLANE];
  logic [mik_pkg::MOT_W-1:0]      out_mot_d [NLANE];

  logic [mik_pkg::MAG_W-1:0]      lane_mag [NLANE];
  logic [mik_pkg::MOT_W-1:0]      lane_mot [NLANE];
  mik_pkg::lane_ctrl_t            lane_ctrl;

  logic                           in_xfer;
  logic                           cmd_zero;
  logic [mik_pkg::RT_HI_W:0]      rt_sum;
  logic [mik_pkg::LIN_W-1:0]      dxy, sxy, rt;

  assign in_xfer  = vel_i.valid && vel_i.ready;
  assign cmd_zero = (vel_i.vel_x == '0) && (vel_i.vel_y == '0) && (vel_i.vel_rot == '0);

  // Lane control follows the sequencer state
  always_comb begin
    lane_ctrl.limited = limited_q;
    case (state_q)
      ST_LOAD: lane_ctrl.op = mik_pkg::LANE_LOAD;
      ST_GAIN: lane_ctrl.op = mik_pkg::LANE_GAIN;
      ST_TAKE: lane_ctrl.op = mik_pkg::LANE_TAKE;
      ST_LIM:  lane_ctrl.op = mik_pkg::LANE_LIM;
      ST_DIV:  lane_ctrl.op = mik_pkg::LANE_DIV;
      default: lane_ctrl.op = mik_pkg::LANE_IDLE;
    endcase
  end

  // Sequencer and datapath next state
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    stop_sent_d = stop_sent_q;
    zero_d      = zero_q;
    limited_d   = limited_q;
    arm_d       = arm_q;
    gain_d      = gain_q;
    limit_d     = limit_q;
    xmy_d       = xmy_q;
    xpy_d       = xpy_q;
    rot_d       = rot_q;
    rt_hi_d     = rt_hi_q;
    rt_lo_d     = rt_lo_q;
    lin_d       = lin_q;
    max_a_d     = max_a_q;
    max_b_d     = max_b_q;
    mx_d        = mx_q;
    out_valid_d = out_valid_q;
    out_cmd_d   = out_cmd_q;
    out_mot_d   = out_mot_q;

    rt_sum = {rt_hi_q[mik_pkg::RT_HI_W-1], rt_hi_q}
           + (rt_lo_q[0] ? {{2{rot_q[mik_pkg::ROT_W-1]}}, rot_q} : '0);
    dxy = mik_pkg::LIN_W'($signed({xmy_q, {mik_pkg::XY_FRAC{1'b0}}}));
    sxy = mik_pkg::LIN_W'($signed({xpy_q, {mik_pkg::XY_FRAC{1'b0}}}));
    rt  = mik_pkg::LIN_W'($signed({rt_hi_q, rt_lo_q}));

    // configuration writes
    if (cfg_we_i) begin
      case (cfg_idx_i)
        mik_pkg::CFG_ARM_SUM:     arm_d   = cfg_data_i[mik_pkg::ARM_W-1:0];
        mik_pkg::CFG_SPEED_GAIN:  gain_d  = cfg_data_i[mik_pkg::GAIN_W-1:0];
        mik_pkg::CFG_SPEED_LIMIT: limit_d = cfg_data_i[mik_pkg::LIM_W-1:0];
        default: begin
        end
      endcase
    end

    // output register drains on transfer
    if (out_valid_q && mot_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          if (cmd_zero) begin
            if (!stop_sent_q) begin
              stop_sent_d = 1'b1;
              zero_d      = 1'b1;
              state_d     = ST_EMIT;
            end
          end else begin
            stop_sent_d = 1'b0;
            zero_d      = 1'b0;
            xmy_d   = {vel_i.vel_x[mik_pkg::XY_W-1], vel_i.vel_x}
                    - {vel_i.vel_y[mik_pkg::XY_W-1], vel_i.vel_y};
            xpy_d   = {vel_i.vel_x[mik_pkg::XY_W-1], vel_i.vel_x}
                    + {vel_i.vel_y[mik_pkg::XY_W-1], vel_i.vel_y};
            rot_d   = vel_i.vel_rot;
            rt_hi_d = '0;
            rt_lo_d = arm_q;
            cnt_d   = mik_pkg::CNT_W'(mik_pkg::ARM_W - 1);
            state_d = ST_RT;
          end
        end
      end
      ST_RT: begin
        rt_hi_d = rt_sum[mik_pkg::RT_HI_W:1];
        rt_lo_d = {rt_sum[0], rt_lo_q[mik_pkg::ARM_W-1:1]};
        if (cnt_q == '0) begin
          state_d = ST_LIN;
        end else begin
          cnt_d = cnt_q - mik_pkg::CNT_W'(1);
        end
      end
      ST_LIN: begin
        lin_d[0] = dxy + rt;
        lin_d[1] = sxy - rt;
        lin_d[2] = sxy + rt;
        lin_d[3] = dxy - rt;
        state_d  = ST_LOAD;
      end
      ST_LOAD: begin
        cnt_d   = mik_pkg::CNT_W'(mik_pkg::GAIN_W - 1);
        state_d = ST_GAIN;
      end
      ST_GAIN: begin
        if (cnt_q == '0) begin
          state_d = ST_TAKE;
        end else begin
          cnt_d = cnt_q - mik_pkg::CNT_W'(1);
        end
      end
      ST_TAKE: begin
        state_d = ST_MAX1;
      end
      ST_MAX1: begin
        max_a_d = (lane_mag[0] > lane_mag[1]) ? lane_mag[0] : lane_mag[1];
        max_b_d = (lane_mag[2] > lane_mag[3]) ? lane_mag[2] : lane_mag[3];
        state_d = ST_MAX2;
      end
      ST_MAX2: begin
        mx_d    = (max_a_q > max_b_q) ? max_a_q : max_b_q;
        state_d = ST_CHECK;
      end
      ST_CHECK: begin
        if (mx_q > mik_pkg::MAG_W'(limit_q)) begin
          limited_d = 1'b1;
          cnt_d     = mik_pkg::CNT_W'(mik_pkg::LIM_W - 1);
          state_d   = ST_LIM;
        end else begin
          limited_d = 1'b0;
          state_d   = ST_EMIT;
        end
      end
      ST_LIM: begin
        if (cnt_q == '0) begin
          cnt_d   = mik_pkg::CNT_W'(mik_pkg::LIM_W - 1);
          state_d = ST_DIV;
        end else begin
          cnt_d = cnt_q - mik_pkg::CNT_W'(1);
        end
      end
      ST_DIV: begin
        if (cnt_q == '0) begin
          state_d = ST_EMIT;
        end else begin
          cnt_d = cnt_q - mik_pkg::CNT_W'(1);
        end
      end
      ST_EMIT: begin
        // wait for room in the output register
        if (!out_valid_q || mot_o.ready) begin
          out_valid_d = 1'b1;
          out_cmd_d   = zero_q ? mik_pkg::CMD_STOP : mik_pkg::CMD_SET;
          for (int i = 0; i < NLANE; i++) begin
            out_mot_d[i] = zero_q ? '0 : lane_mot[i];
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      stop_sent_q <= 1'b0;
      zero_q      <= 1'b0;
      limited_q   <= 1'b0;
      arm_q       <= mik_pkg::ARM_RST;
      gain_q      <= mik_pkg::GAIN_RST;
      limit_q     <= mik_pkg::LIMIT_RST;
      xmy_q       <= '0;
      xpy_q       <= '0;
      rot_q       <= '0;
      rt_hi_q     <= '0;
      rt_lo_q     <= '0;
      for (int i = 0; i < NLANE; i++) begin
        lin_q[i]     <= '0;
        out_mot_q[i] <= '0;
      end
      max_a_q     <= '0;
      max_b_q     <= '0;
      mx_q        <= '0;
      out_valid_q <= 1'b0;
      out_cmd_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      stop_sent_q <= stop_sent_d;
      zero_q      <= zero_d;
      limited_q   <= limited_d;
      arm_q       <= arm_d;
      gain_q      <= gain_d;
      limit_q     <= limit_d;
      xmy_q       <= xmy_d;
      xpy_q       <= xpy_d;
      rot_q       <= rot_d;
      rt_hi_q     <= rt_hi_d;
      rt_lo_q     <= rt_lo_d;
      for (int i = 0; i < NLANE; i++) begin
        lin_q[i]     <= lin_d[i];
        out_mot_q[i] <= out_mot_d[i];
      end
      max_a_q     <= max_a_d;
      max_b_q     <= max_b_d;
      mx_q        <= mx_d;
      out_valid_q <= out_valid_d;
      out_cmd_q   <= out_cmd_d;
    end
  end

  // Wheel lanes; motors two and four are negated
  for (genvar g = 0; g < NLANE; g++) begin : g_lane
    mik_lane u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (lane_ctrl),
      .flip_i  (1'(g % 2)),
      .lin_i   (lin_q[g]),
      .gain_i  (gain_q),
      .limit_i (limit_q),
      .max_i   (mx_q),
      .mag_o   (lane_mag[g]),
      .motor_o (lane_mot[g])
    );
  end

  // Channel ports
  assign vel_i.ready       = (state_q == ST_IDLE);
  assign mot_o.valid       = out_valid_q;
  assign mot_o.command     = out_cmd_q;
  assign mot_o.motor_one   = out_mot_q[0];
  assign mot_o.motor_two   = out_mot_q[1];
  assign mot_o.motor_three = out_mot_q[2];
  assign mot_o.motor_four  = out_mot_q[3];

endmodule

`default_nettype wire

// File: design/mik_lane.sv
// ----------------------------------------------------------------------------
// mik_lane: one wheel lane
// Bit-serial gain multiply, bit-serial limit multiply and restoring divide
// for one motor, followed by sign restore and, when not limited, 16-bit saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module mik_lane (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire  mik_pkg::lane_ctrl_t        ctrl_i,
  input  wire                              flip_i,
  input  wire  [mik_pkg::LIN_W-1:0]        lin_i,
  input  wire  [mik_pkg::GAIN_W-1:0]       gain_i,
  input  wire  [mik_pkg::LIM_W-1:0]        limit_i,
  input  wire  [mik_pkg::MAG_W-1:0]        max_i,
  output logic [mik_pkg::MAG_W-1:0]        mag_o,
  output logic [mik_pkg::MOT_W-1:0]        motor_o
);

  logic [mik_pkg::ABS_W-1:0]  m_q, m_d;      // |wheel speed|
  logic                       neg_q, neg_d;  // motor sign
  logic [mik_pkg::ABS_W-1:0]  acc_q, acc_d;  // gain product, upper part
  logic [mik_pkg::GAIN_W-1:0] sh_q, sh_d;    // gain bits, LSB first
  logic [mik_pkg::MAG_W-1:0]  mag_q, mag_d;  // motor rpm magnitude
  logic [mik_pkg::MAG_W-1:0]  hi_q, hi_d;    // product high / remainder
  logic [mik_pkg::LIM_W-1:0]  lo_q, lo_d;    // product low / quotient

  logic [mik_pkg::LIN_W-1:0]  lin_abs;
  logic [mik_pkg::ABS_W:0]    gsum;
  logic [mik_pkg::MAG_W:0]    lsum;
  logic [mik_pkg::MAG_W:0]    trial;
  logic [mik_pkg::MAG_W:0]    diff;
  logic [mik_pkg::SAT_W-1:0]  sat_bound;
  logic [mik_pkg::SAT_W-1:0]  umag;
  logic [mik_pkg::SAT_W-1:0]  sval;

  // Serial datapath
  always_comb begin
    m_d   = m_q;
    neg_d = neg_q;
    acc_d = acc_q;
    sh_d  = sh_q;
    mag_d = mag_q;
    hi_d  = hi_q;
    lo_d  = lo_q;

    lin_abs = lin_i[mik_pkg::LIN_W-1] ? (~lin_i + mik_pkg::LIN_W'(1)) : lin_i;
    gsum    = {1'b0, acc_q} + (sh_q[0] ? {1'b0, m_q} : '0);
    lsum    = {1'b0, hi_q} + (lo_q[0] ? {1'b0, mag_q} : '0);
    trial   = {hi_q, lo_q[mik_pkg::LIM_W-1]};
    diff    = trial - {1'b0, max_i};

    case (ctrl_i.op)
      mik_pkg::LANE_LOAD: begin
        m_d   = lin_abs[mik_pkg::ABS_W-1:0];
        neg_d = lin_i[mik_pkg::LIN_W-1] ^ flip_i;
        acc_d = '0;
        sh_d  = gain_i;
      end
      mik_pkg::LANE_GAIN: begin
        // add then shift right; dropped bits are below the rpm point
        acc_d = gsum[mik_pkg::ABS_W:1];
        sh_d  = {1'b0, sh_q[mik_pkg::GAIN_W-1:1]};
      end
      mik_pkg::LANE_TAKE: begin
        mag_d = acc_q[mik_pkg::ABS_W-1:mik_pkg::GAIN_DROP];
        hi_d  = '0;
        lo_d  = limit_i;
      end
      mik_pkg::LANE_LIM: begin
        // product low bits shift into the limit register
        hi_d = lsum[mik_pkg::MAG_W:1];
        lo_d = {lsum[0], lo_q[mik_pkg::LIM_W-1:1]};
      end
      mik_pkg::LANE_DIV: begin
        // high part is already below the divisor, so 15 steps suffice
        if (!diff[mik_pkg::MAG_W]) begin
          hi_d = diff[mik_pkg::MAG_W-1:0];
          lo_d = {lo_q[mik_pkg::LIM_W-2:0], 1'b1};
        end else begin
          hi_d = trial[mik_pkg::MAG_W-1:0];
          lo_d = {lo_q[mik_pkg::LIM_W-2:0], 1'b0};
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_q   <= '0;
      neg_q <= 1'b0;
      acc_q <= '0;
      sh_q  <= '0;
      mag_q <= '0;
      hi_q  <= '0;
      lo_q  <= '0;
    end else begin
      m_q   <= m_d;
      neg_q <= neg_d;
      acc_q <= acc_d;
      sh_q  <= sh_d;
      mag_q <= mag_d;
      hi_q  <= hi_d;
      lo_q  <= lo_d;
    end
  end

  // Sign restore and saturation
  always_comb begin
    sat_bound = neg_q ? mik_pkg::SAT_NEG : mik_pkg::SAT_POS;
    if (ctrl_i.limited) begin
      umag = {2'b00, lo_q};
    end else if (mag_q > {{(mik_pkg::MAG_W-mik_pkg::SAT_W){1'b0}}, sat_bound}) begin
      umag = sat_bound;
    end else begin
      umag = mag_q[mik_pkg::SAT_W-1:0];
    end
    sval = neg_q ? (~umag + mik_pkg::SAT_W'(1)) : umag;
  end

  assign mag_o   = mag_q;
  assign motor_o = sval[mik_pkg::MOT_W-1:0];

endmodule

`default_nettype wire

// File: tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: regression bench for the mecanum kinematics limiter
// Sends chassis velocity commands, first from a short directed table and then
// at random, under eight register settings and four idle patterns. Every
// motor result is checked field by field against the table or a local wheel-speed model.
// ----------------------------------------------------------------------------

module tb;
  import mik_pkg::*;

  localparam int NUM_DIRECTED   = 22;
  localparam int NUM_SEGS       = 8;
  localparam int ITEMS_PER_SEG  = 112;
  localparam int SETTLE_CYCLES  = 100;

  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;

  typedef struct packed {
    logic                    command;
    logic signed [MOT_W-1:0] motor_one;
    logic signed [MOT_W-1:0] motor_two;
    logic signed [MOT_W-1:0] motor_three;
    logic signed [MOT_W-1:0] motor_four;
  } motor_cmd_t;

  // How a stimulus row gets its expectation
  typedef enum logic [1:0] {
    ROW_PREDICTED,  // from the wheel-speed model
    ROW_TYPED,      // written into the table
    ROW_SILENT      // no result allowed
  } row_kind_e;

  typedef struct packed {
    row_kind_e               kind;
    logic signed [XY_W-1:0]  vx;
    logic signed [XY_W-1:0]  vy;
    logic signed [ROT_W-1:0] vr;
    motor_cmd_t              want;
  } stim_row_t;

  localparam motor_cmd_t NO_CMD   = '0;
  localparam motor_cmd_t STOP_CMD = '{CMD_STOP, 16'sd0, 16'sd0, 16'sd0, 16'sd0};
  // Full-scale commands under reset settings: every motor hits the 8000 rpm limit
  localparam motor_cmd_t FWD_MAX_CMD  = '{CMD_SET, 16'sd8000, -16'sd8000, 16'sd8000, -16'sd8000};
  localparam motor_cmd_t REV_MAX_CMD  = '{CMD_SET, -16'sd8000, 16'sd8000, -16'sd8000, 16'sd8000};
  localparam motor_cmd_t SIDE_MAX_CMD = '{CMD_SET, -16'sd8000, -16'sd8000, 16'sd8000, 16'sd8000};

  logic                  clk_i  = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  rx_ready = 1'b0;

  mik_vel_if   vel_ch ();
  mik_motor_if mot_ch ();

  assign mot_ch.ready = rx_ready;

  mecanum_inverse_kinematics_limiter_top u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .vel_i      (vel_ch),
    .mot_o      (mot_ch)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Model state and register copies
  logic [ARM_W-1:0]  arm_reg  = ARM_RST;
  logic [GAIN_W-1:0] gain_reg = GAIN_RST;
  logic [LIM_W-1:0]  lim_reg  = LIMIT_RST;
  bit                stop_issued = 1'b0;

  motor_cmd_t expected_cmds[$];

  int n_errors   = 0;
  int n_sent     = 0;
  int n_results  = 0;
  int n_stops    = 0;
  int n_limited  = 0;
  int zero_burst = 0;
  int unsigned tx_idle_pct  = 0;
  int unsigned rx_stall_pct = 0;

  stim_row_t directed_rows [NUM_DIRECTED] = '{
    '{ROW_TYPED,     12'sd0,    12'sd0,    16'sd0,     STOP_CMD},    // first stop
    '{ROW_SILENT,    12'sd0,    12'sd0,    16'sd0,     NO_CMD},      // repeat absorbed
    '{ROW_TYPED,     12'sd2047, 12'sd0,    16'sd0,     FWD_MAX_CMD},
    '{ROW_TYPED,     12'sd0,    12'sd0,    16'sd0,     STOP_CMD},    // stop after motion
    '{ROW_TYPED,     12'sh800,  12'sd0,    16'sd0,     REV_MAX_CMD},
    '{ROW_TYPED,     12'sd0,    12'sd2047, 16'sd0,     SIDE_MAX_CMD},
    '{ROW_PREDICTED, 12'sd0,    12'sh800,  16'sd0,     NO_CMD},
    '{ROW_PREDICTED, 12'sd0,    12'sd0,    16'sd32767, NO_CMD},
    '{ROW_PREDICTED, 12'sd0,    12'sd0,    16'sh8000,  NO_CMD},
    '{ROW_PREDICTED, 12'sd2047, 12'sd2047, 16'sd32767, NO_CMD},
    '{ROW_PREDICTED, 12'sh800,  12'sh800,  16'sh8000,  NO_CMD},
    '{ROW_PREDICTED, 12'sd1,    12'sd0,    16'sd0,     NO_CMD},
    '{ROW_PREDICTED, 12'sd0,    12'sd0,    16'sd1,     NO_CMD},      // motors truncate to 0
    '{ROW_PREDICTED, -12'sd1,   12'sd1,    -16'sd1,    NO_CMD},
    '{ROW_PREDICTED, 12'sd100,  -12'sd50,  16'sd4096,  NO_CMD},
    '{ROW_PREDICTED, 12'sd400,  12'sd100,  16'sd0,     NO_CMD},      // peak equals limit
    '{ROW_PREDICTED, 12'sd401,  12'sd100,  16'sd0,     NO_CMD},      // just over limit
    '{ROW_TYPED,     12'sd0,    12'sd0,    16'sd0,     STOP_CMD},
    '{ROW_SILENT,    12'sd0,    12'sd0,    16'sd0,     NO_CMD},
    '{ROW_SILENT,    12'sd0,    12'sd0,    16'sd0,     NO_CMD},
    '{ROW_PREDICTED, -12'sd1,   12'sd0,    16'sd0,     NO_CMD},      // clears stop state
    '{ROW_TYPED,     12'sd0,    12'sd0,    16'sd0,     STOP_CMD}
  };

  // Wheel speeds, gain scaling, proportional limiting and saturation
  function automatic bit predict_motor_cmd(input logic signed [XY_W-1:0] vx,
                                           input logic signed [XY_W-1:0] vy,
                                           input logic signed [ROT_W-1:0] vr,
                                           output motor_cmd_t res);
    longint surf [4];
    longint rpm [4];
    longint fwd, side, turn, prod;
    longint unsigned peak, amp;
    int i;
    res = STOP_CMD;
    if (vx == 0 && vy == 0 && vr == 0) begin
      if (stop_issued) return 1'b0;
      stop_issued = 1'b1;
      return 1'b1;
    end
    stop_issued = 1'b0;
    // surface speeds in Q.20 cm/s
    fwd  = longint'(vx) * 64'sd1048576;
    side = longint'(vy) * 64'sd1048576;
    turn = longint'(vr) * longint'(arm_reg);
    surf[0] = fwd - side + turn;
    surf[1] = fwd + side - turn;
    surf[2] = fwd + side + turn;
    surf[3] = fwd - side - turn;
    peak = 0;
    for (i = 0; i < 4; i++) begin
      prod = surf[i] * longint'(gain_reg);
      amp = (prod < 0) ? -prod : prod;
      amp = amp >> 36;
      rpm[i] = (prod < 0) ? -longint'(amp) : longint'(amp);
      if (i == 1 || i == 3) rpm[i] = -rpm[i];
      amp = (rpm[i] < 0) ? -rpm[i] : rpm[i];
      if (amp > peak) peak = amp;
    end
    if (peak > lim_reg) begin
      n_limited++;
      for (i = 0; i < 4; i++) begin
        amp = (rpm[i] < 0) ? -rpm[i] : rpm[i];
        amp = amp * lim_reg / peak;
        rpm[i] = (rpm[i] < 0) ? -longint'(amp) : longint'(amp);
      end
    end
    for (i = 0; i < 4; i++) begin
      if (rpm[i] > 32767) rpm[i] = 32767;
      else if (rpm[i] < -32768) rpm[i] = -32768;
    end
    res.command     = CMD_SET;
    res.motor_one   = rpm[0][MOT_W-1:0];
    res.motor_two   = rpm[1][MOT_W-1:0];
    res.motor_three = rpm[2][MOT_W-1:0];
    res.motor_four  = rpm[3][MOT_W-1:0];
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string msg);
    n_errors++;
    $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [MOT_W-1:0] got,
                             input logic [MOT_W-1:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0d want %0d", name, $signed(got), $signed(want)));
  endtask

  task automatic check_motor_cmd();
    motor_cmd_t want;
    n_results++;
    if (mot_ch.command == CMD_STOP) n_stops++;
    if (expected_cmds.size() == 0) begin
      report_mismatch("motor result with nothing expected");
      return;
    end
    want = expected_cmds.pop_front();
    check_field("command", MOT_W'(mot_ch.command), MOT_W'(want.command));
    check_field("motor_one", mot_ch.motor_one, want.motor_one);
    check_field("motor_two", mot_ch.motor_two, want.motor_two);
    check_field("motor_three", mot_ch.motor_three, want.motor_three);
    check_field("motor_four", mot_ch.motor_four, want.motor_four);
  endtask

  // Receiver: random back-pressure
  always @(posedge clk_i) begin
    rx_ready <= ($urandom_range(99) >= rx_stall_pct);
  end

  // Result monitor: values sampled are the ones before the edge
  always @(posedge clk_i) begin
    if (rst_ni && mot_ch.valid && mot_ch.ready) begin
      check_motor_cmd();
    end
  end

  // One velocity command transfer; valid is left high for back-to-back sends
  task automatic send_vel_cmd(input stim_row_t row, output bit produced);
    motor_cmd_t guess;
    while ($urandom_range(99) < tx_idle_pct) begin
      vel_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    vel_ch.valid   <= 1'b1;
    vel_ch.vel_x   <= row.vx;
    vel_ch.vel_y   <= row.vy;
    vel_ch.vel_rot <= row.vr;
    do @(posedge clk_i); while (!vel_ch.ready);
    n_sent++;
    produced = predict_motor_cmd(row.vx, row.vy, row.vr, guess);
    case (row.kind)
      ROW_PREDICTED: if (produced) expected_cmds.push_back(guess);
      ROW_TYPED:     expected_cmds.push_back(row.want);
      default:       ;
    endcase
  endtask

  function automatic logic [15:0] corner_value(input int unsigned width);
    logic [15:0] top;
    top = 16'd1 << (width - 1);
    case ($urandom_range(4))
      0:       return top;            // most negative
      1:       return '1;             // minus one
      2:       return '0;
      3:       return 16'd1;
      default: return top - 16'd1;    // most positive
    endcase
  endfunction

  // Mix of stop bursts, corner values, slow motion and full-range commands
  function automatic stim_row_t random_vel_cmd();
    stim_row_t r;
    logic [15:0] c;
    int unsigned pick;
    r = '0;
    r.kind = ROW_PREDICTED;
    pick = $urandom_range(99);
    if (zero_burst > 0) begin
      zero_burst--;
      return r;
    end
    if (pick < 8) begin
      zero_burst = $urandom_range(3);
    end else if (pick < 28) begin
      c = corner_value(XY_W);
      r.vx = c[XY_W-1:0];
      c = corner_value(XY_W);
      r.vy = c[XY_W-1:0];
      r.vr = corner_value(ROT_W);
    end else if (pick < 63) begin
      r.vx = XY_W'(int'($urandom_range(600)) - 300);
      r.vy = XY_W'(int'($urandom_range(600)) - 300);
      r.vr = ROT_W'(int'($urandom_range(6000)) - 3000);
    end else begin
      r.vx = XY_W'($urandom);
      r.vy = XY_W'($urandom);
      r.vr = ROT_W'($urandom);
    end
    return r;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    case (idx)
      CFG_ARM_SUM:     arm_reg  = data[ARM_W-1:0];
      CFG_SPEED_GAIN:  gain_reg = data[GAIN_W-1:0];
      CFG_SPEED_LIMIT: lim_reg  = data[LIM_W-1:0];
      default:         ;  // unmapped index is ignored
    endcase
  endtask

  // Register settings per segment; upper data bits carry junk to test masking
  task automatic load_settings(input int seg);
    logic [ARM_W-1:0]  a;
    logic [GAIN_W-1:0] g;
    logic [LIM_W-1:0]  l;
    a = ARM_W'($urandom);
    g = GAIN_W'($urandom);
    l = LIM_W'($urandom);
    case (seg)
      1: begin a = '1; g = '1; l = '1; end
      2: begin a = '0; g = '0; l = '0; end
      3: begin a = 16'd2560; g = 24'd65536; l = '0; end       // zero limit, unity gain
      5: begin a = '1; g = 24'd1; l = 15'd1; end
      6: begin a = '0; g = '1; l = '1; end
      default: ;
    endcase
    write_reg(CFG_ARM_SUM, {8'($urandom), a});
    write_reg(CFG_SPEED_GAIN, g);
    write_reg(CFG_SPEED_LIMIT, {9'($urandom), l});
    write_reg(CFG_UNMAPPED, CFG_DATA_W'($urandom));
    cfg_we <= 1'b0;
  endtask

  task automatic set_idle_mode(input int mode);
    case (mode)
      1:       begin tx_idle_pct = 62; rx_stall_pct = 0;  end
      2:       begin tx_idle_pct = 0;  rx_stall_pct = 62; end
      3:       begin tx_idle_pct = 17; rx_stall_pct = 17; end
      default: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
    endcase
  endtask

  // Wait out all results, then the pipeline latency
  task automatic drain_and_settle();
    vel_ch.valid <= 1'b0;
    while (expected_cmds.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Main sequence
  initial begin
    bit produced;
    int k, seg, done;
    vel_ch.valid   <= 1'b0;
    vel_ch.vel_x   <= '0;
    vel_ch.vel_y   <= '0;
    vel_ch.vel_rot <= '0;
    cfg_we         <= 1'b0;
    cfg_idx        <= '0;
    cfg_data       <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed table at reset settings
    set_idle_mode(0);
    for (k = 0; k < NUM_DIRECTED; k++) send_vel_cmd(directed_rows[k], produced);

    // random segments, each with its own settings and idle pattern
    for (seg = 0; seg < NUM_SEGS; seg++) begin
      drain_and_settle();
      if (seg != 0) load_settings(seg);
      set_idle_mode(seg % 4);
      done = 0;
      while (done < ITEMS_PER_SEG) begin
        send_vel_cmd(random_vel_cmd(), produced);
        done++;
      end
    end
    drain_and_settle();

    $display("Sent %0d velocity commands over %0d register settings and four idle patterns.",
             n_sent, NUM_SEGS);
    $display("Checked %0d motor results: %0d stops, %0d speed-limited.",
             n_results, n_stops, n_limited);
    if (n_errors == 0) begin
      $display("mecanum_inverse_kinematics_limiter_top regression: pass");
    end else begin
      $display("mecanum_inverse_kinematics_limiter_top regression: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10ms;
    $display("Timed out with %0d results outstanding.", expected_cmds.size());
    $display("mecanum_inverse_kinematics_limiter_top regression: fail");
    $finish;
  end

endmodule
